// ===== hdl/sha1_hash_engine_assert.svh =====
// Assertion macros for the SHA-1 hash engine.
// Each macro takes a label, a clock, an active-low reset, a condition and a consequence.
`ifndef SHA1_HASH_ENGINE_ASSERT_SVH
`define SHA1_HASH_ENGINE_ASSERT_SVH

`ifndef SYNTH
`define SHA1_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("SHA-1 engine assertion failed in the same cycle");
`define SHA1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("SHA-1 engine assertion failed one cycle later");
`else
`define SHA1_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SHA1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/sha1_pkg.sv =====
`default_nettype none

package sha1_pkg;

	localparam int unsigned ROUNDS = 80;

	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
	localparam logic [7:0] PAD_ZERO_BYTE = 8'h00;

	// Byte offsets inside a 64-byte block.
	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [5:0] FILL_LEN_START_M1 = 6'd55;

	localparam logic [2:0] LAST_WORD_IDX = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		PAD_NONE,
		PAD_MARK,
		PAD_ZERO,
		PAD_LEN,
		PAD_DONE
	} pad_t;

	// Control from the sequencer to the schedule memory.
	typedef struct packed {
		logic       wr_en;
		logic [3:0] wr_addr;
		logic       rd_en;
		logic [3:0] rd_addr;
		logic       step;
		logic       from_mem;
	} sched_ctl_t;

	function automatic logic [31:0] rotl1(input logic [31:0] x);
		rotl1 = {x[30:0], x[31]};
	endfunction

	function automatic logic [31:0] rotl5(input logic [31:0] x);
		rotl5 = {x[26:0], x[31:27]};
	endfunction

	function automatic logic [31:0] rotl30(input logic [31:0] x);
		rotl30 = {x[1:0], x[31:2]};
	endfunction

	// Round function, chosen by the round number.
	function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		if (rnd < 7'd20) begin
			round_f = (b & c) | (~b & d);
		end else if (rnd < 7'd40) begin
			round_f = b ^ c ^ d;
		end else if (rnd < 7'd60) begin
			round_f = (b & c) | (b & d) | (c & d);
		end else begin
			round_f = b ^ c ^ d;
		end
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] rnd);
		if (rnd < 7'd20) begin
			round_k = K0;
		end else if (rnd < 7'd40) begin
			round_k = K1;
		end else if (rnd < 7'd60) begin
			round_k = K2;
		end else begin
			round_k = K3;
		end
	endfunction

endpackage

`default_nettype wire

// ===== hdl/sha1_if.sv =====
`default_nettype none

// Message channel: one byte word per handshake, with an end marker.
interface sha1_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, output data_byte, output byte_present,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input byte_present,
		input end_of_message, output ready);
endinterface

// Digest channel: one 32-bit digest word per handshake.
interface sha1_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        final_word;

	modport source (output valid, output digest_word, output word_index,
		output final_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input final_word, output ready);
endinterface

`default_nettype wire

// ===== hdl/sha1_sched.sv =====
`default_nettype none

// Block word memory and message schedule window.
// Rounds 0 to 15 take their word from the memory; later rounds derive it
// from the sixteen-word window of earlier schedule words.
module sha1_sched (
	input  wire logic                    clk,
	input  wire sha1_pkg::sched_ctl_t    ctl,
	input  wire logic [31:0]             wr_data,
	output logic [31:0]                  wt
);

	logic [31:0] mem [16];
	logic [31:0] rdata_q;
	logic [31:0] win_q [16];

	// Single write port, single registered read port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[ctl.rd_addr];
		end
	end

	// Schedule word for the current round.
	assign wt = ctl.from_mem ? rdata_q
		: sha1_pkg::rotl1(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0]);

	// The window holds the last sixteen schedule words, oldest at index 0.
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= wt;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sha1_hash_engine.sv =====
`default_nettype none

// SHA-1 hash engine.
// The msg channel carries one word per handshake: a data byte with a present
// flag and an end-of-message flag. An end marker without a byte finishes the
// message with the bytes given so far, including the empty message.
// The dig channel returns the 160-bit digest as five words, H0 first, with
// word_index 0 to 4 and final_word set on the last one.
// Bytes are taken one per cycle while the engine is idle. Every 64th byte
// starts a compression: one memory read ahead, 80 rounds at one round per
// cycle, and an add into the chaining value; msg.ready is low meanwhile.
// Sustained throughput is set by the single round unit.
// After the end marker the padding and length bytes are generated at one per
// cycle (9 to 72 bytes) with one or two compressions, then the digest moves
// into an output buffer and the next message may start at once.
// If the receiver stalls, the buffer holds; a following digest waits in the
// engine, with msg.ready low, until the buffer has drained.
// Reset restores the initial chaining value and clears the length, the fill
// count and the output buffer's busy flag and word index.
module sha1_hash_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	sha1_in_if.sink          msg,
	sha1_out_if.source       dig
);

	sha1_pkg::state_t     state_q, state_d;
	sha1_pkg::pad_t       pad_q;
	sha1_pkg::sched_ctl_t sctl;

	logic [31:0] chain_q [5];
	logic [31:0] work_q  [5];
	logic [63:0] msg_bits_q;
	logic [5:0]  fill_q;
	logic [23:0] word_q;
	logic [6:0]  round_q;

	logic [31:0] dig_q [5];
	logic [2:0]  out_idx_q;
	logic        out_busy_q;

	logic        accept;
	logic        put_en;
	logic [7:0]  put_byte;
	logic [63:0] len_shift;
	logic [31:0] wt;
	logic [31:0] t_sum;
	logic        out_take;
	logic        block_full;

	assign accept     = msg.valid && msg.ready;
	assign out_take   = dig.valid && dig.ready;
	assign block_full = (fill_q == sha1_pkg::FILL_LAST);

	// Length byte for the current offset: offset 56 carries the top byte.
	assign len_shift = msg_bits_q >> {~fill_q[2:0], 3'b000};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha1_pkg::ST_IDLE: begin
				if (accept) begin
					if (msg.byte_present && block_full) begin
						state_d = sha1_pkg::ST_LOAD;
					end else if (msg.end_of_message) begin
						state_d = sha1_pkg::ST_PAD;
					end
				end
			end
			sha1_pkg::ST_PAD: begin
				if (block_full) begin
					state_d = sha1_pkg::ST_LOAD;
				end
			end
			sha1_pkg::ST_LOAD: begin
				state_d = sha1_pkg::ST_ROUND;
			end
			sha1_pkg::ST_ROUND: begin
				if (round_q == 7'(sha1_pkg::ROUNDS - 1)) begin
					state_d = sha1_pkg::ST_ADD;
				end
			end
			sha1_pkg::ST_ADD: begin
				if (pad_q == sha1_pkg::PAD_DONE) begin
					state_d = sha1_pkg::ST_DONE;
				end else if (pad_q == sha1_pkg::PAD_NONE) begin
					state_d = sha1_pkg::ST_IDLE;
				end else begin
					state_d = sha1_pkg::ST_PAD;
				end
			end
			sha1_pkg::ST_DONE: begin
				if (!out_busy_q) begin
					state_d = sha1_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha1_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: handshake, byte source and memory control.
	always_comb begin
		msg.ready     = 1'b0;
		put_en        = 1'b0;
		put_byte      = msg.data_byte;
		sctl          = '0;
		sctl.from_mem = (round_q[6:4] == 3'd0);
		unique case (state_q)
			sha1_pkg::ST_IDLE: begin
				msg.ready = 1'b1;
				put_en    = accept && msg.byte_present;
			end
			sha1_pkg::ST_PAD: begin
				put_en = 1'b1;
				unique case (pad_q)
					sha1_pkg::PAD_MARK: put_byte = sha1_pkg::PAD_MARK_BYTE;
					sha1_pkg::PAD_LEN:  put_byte = len_shift[7:0];
					default:            put_byte = sha1_pkg::PAD_ZERO_BYTE;
				endcase
			end
			sha1_pkg::ST_LOAD: begin
				sctl.rd_en   = 1'b1;
				sctl.rd_addr = 4'd0;
			end
			sha1_pkg::ST_ROUND: begin
				sctl.rd_en   = 1'b1;
				sctl.rd_addr = round_q[3:0] + 4'd1;
				sctl.step    = 1'b1;
			end
			default: begin
			end
		endcase
		sctl.wr_en   = put_en && (fill_q[1:0] == 2'd3);
		sctl.wr_addr = fill_q[5:2];
	end

	sha1_sched u_sched (
		.clk     (clk),
		.ctl     (sctl),
		.wr_data ({word_q, put_byte}),
		.wt      (wt)
	);

	// One compression round.
	assign t_sum = sha1_pkg::rotl5(work_q[0])
		+ sha1_pkg::round_f(round_q, work_q[1], work_q[2], work_q[3])
		+ work_q[4] + sha1_pkg::round_k(round_q) + wt;

	// Sequencer state, fill count, length and chaining value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sha1_pkg::ST_IDLE;
			pad_q      <= sha1_pkg::PAD_NONE;
			fill_q     <= '0;
			msg_bits_q <= '0;
			round_q    <= '0;
			chain_q[0] <= sha1_pkg::H0_INIT;
			chain_q[1] <= sha1_pkg::H1_INIT;
			chain_q[2] <= sha1_pkg::H2_INIT;
			chain_q[3] <= sha1_pkg::H3_INIT;
			chain_q[4] <= sha1_pkg::H4_INIT;
		end else begin
			state_q <= state_d;

			if (put_en) begin
				fill_q <= fill_q + 6'd1;
			end

			if (accept && msg.byte_present) begin
				msg_bits_q <= msg_bits_q + 64'd8;
			end

			// Padding phases advance with each generated byte.
			if (accept && msg.end_of_message) begin
				pad_q <= sha1_pkg::PAD_MARK;
			end else if (state_q == sha1_pkg::ST_PAD) begin
				unique case (pad_q)
					sha1_pkg::PAD_MARK: begin
						pad_q <= (fill_q == sha1_pkg::FILL_LEN_START_M1)
							? sha1_pkg::PAD_LEN : sha1_pkg::PAD_ZERO;
					end
					sha1_pkg::PAD_ZERO: begin
						if (fill_q == sha1_pkg::FILL_LEN_START_M1) begin
							pad_q <= sha1_pkg::PAD_LEN;
						end
					end
					sha1_pkg::PAD_LEN: begin
						if (block_full) begin
							pad_q <= sha1_pkg::PAD_DONE;
						end
					end
					default: begin
					end
				endcase
			end

			if (state_q == sha1_pkg::ST_ROUND) begin
				round_q <= round_q + 7'd1;
			end else begin
				round_q <= '0;
			end

			if (state_q == sha1_pkg::ST_ADD) begin
				for (int i = 0; i < 5; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
			end

			// Hand the digest to the output buffer and start a new message.
			if (state_q == sha1_pkg::ST_DONE && !out_busy_q) begin
				pad_q      <= sha1_pkg::PAD_NONE;
				msg_bits_q <= '0;
				chain_q[0] <= sha1_pkg::H0_INIT;
				chain_q[1] <= sha1_pkg::H1_INIT;
				chain_q[2] <= sha1_pkg::H2_INIT;
				chain_q[3] <= sha1_pkg::H3_INIT;
				chain_q[4] <= sha1_pkg::H4_INIT;
			end
		end
	end

	// Byte assembly and working variables.
	always_ff @(posedge clk) begin
		if (put_en) begin
			word_q <= {word_q[15:0], put_byte};
		end
		if (state_q == sha1_pkg::ST_LOAD) begin
			for (int i = 0; i < 5; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (state_q == sha1_pkg::ST_ROUND) begin
			work_q[0] <= t_sum;
			work_q[1] <= work_q[0];
			work_q[2] <= sha1_pkg::rotl30(work_q[1]);
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3];
		end
	end

	// Output buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_busy_q <= 1'b0;
			out_idx_q  <= '0;
		end else begin
			if (state_q == sha1_pkg::ST_DONE && !out_busy_q) begin
				out_busy_q <= 1'b1;
				out_idx_q  <= '0;
			end else if (out_take) begin
				if (out_idx_q == sha1_pkg::LAST_WORD_IDX) begin
					out_busy_q <= 1'b0;
					out_idx_q  <= '0;
				end else begin
					out_idx_q <= out_idx_q + 3'd1;
				end
			end
		end
	end

	// Output buffer data.
	always_ff @(posedge clk) begin
		if (state_q == sha1_pkg::ST_DONE && !out_busy_q) begin
			for (int i = 0; i < 5; i++) begin
				dig_q[i] <= chain_q[i];
			end
		end
	end

	assign dig.valid       = out_busy_q;
	assign dig.digest_word = dig_q[out_idx_q];
	assign dig.word_index  = out_idx_q;
	assign dig.final_word  = (out_idx_q == sha1_pkg::LAST_WORD_IDX);

	`include "sha1_hash_engine_assert.svh"

	`SHA1_ASSERT_SAME(a_round_range, clk, arst_n, state_q == sha1_pkg::ST_ROUND, round_q < 7'(sha1_pkg::ROUNDS))
	`SHA1_ASSERT_SAME(a_out_index, clk, arst_n, dig.valid, out_idx_q <= sha1_pkg::LAST_WORD_IDX)
	`SHA1_ASSERT_NEXT(a_end_leaves_idle, clk, arst_n, accept && msg.end_of_message, state_q != sha1_pkg::ST_IDLE)
	`SHA1_ASSERT_NEXT(a_final_drains, clk, arst_n, out_take && dig.final_word, !out_busy_q)

endmodule

`default_nettype wire
